### hw/rtl/link_keepalive_controller_assert.svh
// ---------------------------------------------------------------------------
// link_keepalive_controller_assert.svh
// Assertion macros for the link keepalive controller. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LINK_KEEPALIVE_CONTROLLER_ASSERT_SVH
`define LINK_KEEPALIVE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is active
`define LKC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is active
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/lkc_pkg.sv
// ---------------------------------------------------------------------------
// lkc_pkg
// Types, codes, reset values and counter helpers of the link keepalive
// controller.
// ---------------------------------------------------------------------------
package lkc_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int CFG_W       = 24;
    localparam int CNT_W       = COUNT_WIDTH + 1;
    localparam int CALC_W      = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 2;
    localparam int ADDR_W      = 4;
    localparam int APB_DATA_W  = 32;
    localparam int LEN_W       = 16;

    localparam logic [CFG_W-1:0] TICK_STEP_RST     = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] SILENCE_LIMIT_RST = CFG_W'(10000000);
    localparam logic [CFG_W-1:0] ACK_LIMIT_RST     = CFG_W'(2000000);
    localparam logic [CFG_W-1:0] RETRY_LIMIT_RST   = CFG_W'(5000000);

    typedef logic signed [CNT_W-1:0]  t_count;
    typedef logic signed [CALC_W-1:0] t_calc;

    localparam t_calc CNT_HI = {{(CALC_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    localparam t_calc CNT_LO = ~CNT_HI;

    typedef enum logic [1:0] {
        REG_TICK_STEP     = 2'd0,
        REG_SILENCE_LIMIT = 2'd1,
        REG_ACK_LIMIT     = 2'd2,
        REG_RETRY_LIMIT   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        LS_NOT_INITED   = 3'd0,
        LS_INITED       = 3'd1,
        LS_DISCONNECTED = 3'd2,
        LS_CONNECTED    = 3'd3,
        LS_WAIT_ACK     = 3'd4
    } t_link_state;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_RECEIVE = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_SEND    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        MSG_CONREQ    = 3'd0,
        MSG_CONRSP    = 3'd1,
        MSG_CONUPD    = 3'd2,
        MSG_CONUPDACK = 3'd3,
        MSG_CONCLOSE  = 3'd4,
        MSG_TRANSFER  = 3'd5,
        MSG_UNKNOWN   = 3'd6
    } t_msg_kind;

    typedef enum logic [2:0] {
        TX_CONREQ    = 3'd0,
        TX_CONUPD    = 3'd1,
        TX_CONUPDACK = 3'd2,
        TX_CONCLOSE  = 3'd3,
        TX_TRANSFER  = 3'd4
    } t_tx_kind;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_REJECT = 2'd1,
        STS_BADARG = 2'd2
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0] tick_step;
        logic [CFG_W-1:0] silence_limit;
        logic [CFG_W-1:0] ack_limit;
        logic [CFG_W-1:0] retry_limit;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [2:0]       command;
        logic [2:0]       msg_kind;
        logic [LEN_W-1:0] payload_length;
    } t_item;

    typedef struct packed {
        logic        send_valid;
        t_tx_kind    send_kind;
        logic        deliver;
        logic        error_report;
        t_status     status;
        t_link_state link_state;
    } t_result;

    function automatic t_calc ext_count(input t_count c);
        return t_calc'(c);
    endfunction

    function automatic t_calc ext_cfg(input logic [CFG_W-1:0] v);
        return t_calc'({{(CALC_W-CFG_W){1'b0}}, v});
    endfunction

    // clamp to the signed counter range
    function automatic t_count sat_count(input t_calc v);
        t_count r;
        if (v > CNT_HI) begin
            r = t_count'(CNT_HI[CNT_W-1:0]);
        end else if (v < CNT_LO) begin
            r = t_count'(CNT_LO[CNT_W-1:0]);
        end else begin
            r = t_count'(v[CNT_W-1:0]);
        end
        return r;
    endfunction

endpackage

### hw/rtl/link_keepalive_controller.sv
// ---------------------------------------------------------------------------
// link_keepalive_controller
// Client side of a connection keepalive protocol: link state, reconnect,
// silence and acknowledge counters, one result per item.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: command[2:0], msg_kind[5:3]; tdata: payload_length
//  m_axis    out        tuser: send_kind; tdata: flags, status, link_state
//  apb       in/out     tick_step, silence_limit, ack_limit, retry_limit
//
//  One item per cycle sustained while m_axis_tready stays high; each item passes
//  the input register, then the result register written by the state machine.
//  Reset is synchronous: link not started, counters zero, registers at their
//  reset values. A stalled result holds; one more item may wait in the input
//  register, and s_axis_tready drops only when both stages are full.
// ---------------------------------------------------------------------------
module link_keepalive_controller
    import lkc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [LEN_W-1:0]      s_axis_tdata,   // payload_length[15:0]
    input  logic [5:0]            s_axis_tuser,   // command[2:0], msg_kind[5:3]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // send_valid[0], deliver[1], error_report[2], status[4:3], link_state[7:5]
    output logic [7:0]            m_axis_tdata,
    output logic [2:0]            m_axis_tuser,   // send_kind[2:0]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_item   r_item;
    logic    w_take;
    logic    w_accept;
    logic    w_out_valid;
    t_result w_result;

    assign s_axis_tready = !r_item.valid || w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (w_accept) begin
            r_item.valid <= 1'b1;
        end else if (w_take) begin
            r_item.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.command        <= s_axis_tuser[2:0];
            r_item.msg_kind       <= s_axis_tuser[5:3];
            r_item.payload_length <= s_axis_tdata;
        end
    end

    lkc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lkc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (r_item),
        .o_take      (w_take),
        .i_out_ready (m_axis_tready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tuser  = w_result.send_kind;
    assign m_axis_tdata  = {w_result.link_state, w_result.status, w_result.error_report,
                            w_result.deliver, w_result.send_valid};

endmodule

### hw/rtl/lkc_cfg.sv
// ---------------------------------------------------------------------------
// lkc_cfg
// APB register file: tick step and the three counter reload values.
// ---------------------------------------------------------------------------
module lkc_cfg
    import lkc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_step     <= TICK_STEP_RST;
            r_cfg.silence_limit <= SILENCE_LIMIT_RST;
            r_cfg.ack_limit     <= ACK_LIMIT_RST;
            r_cfg.retry_limit   <= RETRY_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TICK_STEP:     r_cfg.tick_step     <= pwdata[CFG_W-1:0];
                REG_SILENCE_LIMIT: r_cfg.silence_limit <= pwdata[CFG_W-1:0];
                REG_ACK_LIMIT:     r_cfg.ack_limit     <= pwdata[CFG_W-1:0];
                REG_RETRY_LIMIT:   r_cfg.retry_limit   <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TICK_STEP:     prdata = APB_DATA_W'(r_cfg.tick_step);
            REG_SILENCE_LIMIT: prdata = APB_DATA_W'(r_cfg.silence_limit);
            REG_ACK_LIMIT:     prdata = APB_DATA_W'(r_cfg.ack_limit);
            REG_RETRY_LIMIT:   prdata = APB_DATA_W'(r_cfg.retry_limit);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/lkc_engine.sv
// ---------------------------------------------------------------------------
// lkc_engine
// Link state machine, the three saturating down-counters and the result
// register. One staged input item is resolved per cycle unless the result stalls.
// ---------------------------------------------------------------------------
`include "link_keepalive_controller_assert.svh"

module lkc_engine
    import lkc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output logic    o_take,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_result
);

    t_link_state r_state, n_state;
    t_count      r_retry, n_retry;
    t_count      r_silence, n_silence;
    t_count      r_ack, n_ack;

    logic        r_out_valid;
    t_result     r_result, n_result;

    logic        w_adv;
    t_cmd        w_cmd;
    t_msg_kind   w_kind;
    t_count      w_retry_dec, w_silence_dec, w_ack_dec;
    t_count      w_retry_load, w_silence_load, w_ack_load;
    logic        w_started;

    assign w_adv  = i_item.valid && (!r_out_valid || i_out_ready);
    assign o_take = w_adv;
    assign w_cmd  = t_cmd'(i_item.command);
    assign w_kind = t_msg_kind'(i_item.msg_kind);

    assign w_retry_dec    = sat_count(ext_count(r_retry) - ext_cfg(i_cfg.tick_step));
    assign w_silence_dec  = sat_count(ext_count(r_silence) - ext_cfg(i_cfg.tick_step));
    assign w_ack_dec      = sat_count(ext_count(r_ack) - ext_cfg(i_cfg.tick_step));
    assign w_retry_load   = sat_count(ext_cfg(i_cfg.retry_limit));
    assign w_silence_load = sat_count(ext_cfg(i_cfg.silence_limit));
    assign w_ack_load     = sat_count(ext_cfg(i_cfg.ack_limit));

    assign w_started = (r_state == LS_DISCONNECTED) || (r_state == LS_CONNECTED) ||
                       (r_state == LS_WAIT_ACK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= LS_NOT_INITED;
            r_retry   <= '0;
            r_silence <= '0;
            r_ack     <= '0;
        end else if (w_adv) begin
            r_state   <= n_state;
            r_retry   <= n_retry;
            r_silence <= n_silence;
            r_ack     <= n_ack;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_retry   = r_retry;
        n_silence = r_silence;
        n_ack     = r_ack;
        n_result.send_valid   = 1'b0;
        n_result.send_kind    = TX_CONREQ;
        n_result.deliver      = 1'b0;
        n_result.error_report = 1'b0;
        n_result.status       = STS_OK;

        unique case (w_cmd)
            CMD_TICK: begin
                if (r_state == LS_DISCONNECTED) begin
                    if (r_retry > t_count'(0)) begin
                        n_retry = w_retry_dec;
                    end else begin
                        n_result.send_valid = 1'b1;
                        n_result.send_kind  = TX_CONREQ;
                        n_retry             = w_retry_load;
                    end
                end else if (r_state == LS_WAIT_ACK) begin
                    n_ack = w_ack_dec;
                    if (w_ack_dec <= t_count'(0)) begin
                        n_state = LS_DISCONNECTED;
                    end
                end else if (r_state == LS_CONNECTED) begin
                    n_silence = w_silence_dec;
                    if (w_silence_dec <= t_count'(0)) begin
                        n_result.send_valid = 1'b1;
                        n_result.send_kind  = TX_CONUPD;
                        n_state             = LS_WAIT_ACK;
                    end
                end
            end
            CMD_RECEIVE: begin
                if (!w_started) begin
                    n_result.status = STS_REJECT;
                end else begin
                    unique case (w_kind)
                        MSG_CONREQ: begin
                        end
                        MSG_CONRSP: begin
                            n_state   = LS_CONNECTED;
                            n_silence = w_silence_load;
                            n_ack     = w_ack_load;
                        end
                        MSG_CONUPD: begin
                            n_result.send_valid = 1'b1;
                            if (r_state == LS_CONNECTED) begin
                                n_result.send_kind = TX_CONUPDACK;
                            end else begin
                                n_result.send_kind = TX_CONCLOSE;
                                n_result.status    = STS_REJECT;
                            end
                            if (r_state == LS_WAIT_ACK) begin
                                n_state = LS_CONNECTED;
                            end
                            n_silence = w_silence_load;
                            n_ack     = w_ack_load;
                        end
                        MSG_CONUPDACK: begin
                            if (r_state == LS_WAIT_ACK) begin
                                n_state   = LS_CONNECTED;
                                n_silence = w_silence_load;
                                n_ack     = w_ack_load;
                            end else begin
                                n_result.status = STS_REJECT;
                            end
                        end
                        MSG_CONCLOSE: begin
                            if (r_state == LS_CONNECTED) begin
                                n_result.send_valid = 1'b1;
                                n_result.send_kind  = TX_CONCLOSE;
                                n_state             = LS_NOT_INITED;
                                n_retry             = '0;
                                n_silence           = '0;
                                n_ack               = '0;
                            end else begin
                                n_result.status = STS_REJECT;
                            end
                        end
                        MSG_TRANSFER: begin
                            if (r_state == LS_CONNECTED) begin
                                n_silence        = w_silence_load;
                                n_ack            = w_ack_load;
                                n_result.deliver = 1'b1;
                            end else begin
                                n_result.status = STS_REJECT;
                            end
                        end
                        default: begin
                            n_result.status = STS_REJECT;
                        end
                    endcase
                end
            end
            CMD_START: begin
                if (r_state == LS_NOT_INITED) begin
                    // zero retry count makes the next tick send a connect request
                    n_state   = LS_DISCONNECTED;
                    n_retry   = '0;
                    n_silence = w_silence_load;
                    n_ack     = w_ack_load;
                end else begin
                    n_result.status = STS_REJECT;
                end
            end
            CMD_STOP: begin
                if (r_state != LS_NOT_INITED) begin
                    if (r_state == LS_CONNECTED) begin
                        n_result.send_valid = 1'b1;
                        n_result.send_kind  = TX_CONCLOSE;
                    end
                    n_state   = LS_NOT_INITED;
                    n_retry   = '0;
                    n_silence = '0;
                    n_ack     = '0;
                end
            end
            CMD_SEND: begin
                if (i_item.payload_length == '0) begin
                    n_result.error_report = 1'b1;
                    n_result.status       = STS_BADARG;
                end else if ((r_state == LS_CONNECTED) || (r_state == LS_WAIT_ACK)) begin
                    n_result.send_valid = 1'b1;
                    n_result.send_kind  = TX_TRANSFER;
                end else begin
                    n_result.status = STS_REJECT;
                end
            end
            default: begin
                n_result.status = STS_REJECT;
            end
        endcase

        n_result.link_state = n_state;
    end

    // result register: hold until taken, reload on every advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `LKC_ASSERT_IMPL(a_idle_kind_zero, i_clk, i_rst_n, r_out_valid && !r_result.send_valid, r_result.send_kind == TX_CONREQ, "send kind set without a message")
    `LKC_ASSERT_IMPL(a_err_badarg, i_clk, i_rst_n, r_out_valid && r_result.error_report, r_result.status == STS_BADARG && !r_result.send_valid, "error report without bad argument status")
    `LKC_ASSERT_IMPL(a_deliver_conn, i_clk, i_rst_n, r_out_valid && r_result.deliver, r_result.link_state == LS_CONNECTED && r_result.status == STS_OK, "delivery outside connected state")
    `LKC_ASSERT_IMPL(a_idle_counters, i_clk, i_rst_n, r_state == LS_NOT_INITED, r_retry == '0 && r_silence == '0 && r_ack == '0, "counters not cleared while not started")
    `LKC_ASSERT_NEXT(a_state_follows, i_clk, i_rst_n, w_adv, r_state == r_result.link_state, "reported link state differs from state register")

endmodule
